### src/ljpk_pkg.sv
// ----------------------------------------------------------------------------
// ljpk_pkg
// Shared widths, types and arithmetic helpers of the Lennard-Jones pair kick.
// ----------------------------------------------------------------------------
package ljpk_pkg;

  localparam int POS_FRAC_BITS = 16;

  localparam int POS_W     = 24;
  localparam int D_W       = 27;   // signed minimum-image displacement
  localparam int MAG_W     = 26;
  localparam int SQ_W      = 2 * MAG_W;
  localparam int R2_W      = 54;
  localparam int RT_W      = R2_W / 2;
  localparam int KICK_W    = 32;
  localparam int STEP_W    = 16;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int WORD_W    = 64;
  localparam int PROD_W    = 2 * WORD_W;
  localparam int EPS24_W   = POS_W + 5;

  localparam int SQRT_STAGES = RT_W;
  localparam int DIV_STAGES  = WORD_W;
  localparam int MUL_STAGES  = 2;

  // input regs, sqrt, sigma/r divide, five multiplies with saturation regs,
  // 2u stage, force divide, floor and product stages, kick divide, scale, output
  localparam int PIPE_LAT = 3 + SQRT_STAGES + DIV_STAGES + 5 * (MUL_STAGES + 1) + 1
                            + DIV_STAGES + 2 + DIV_STAGES + 2;

  localparam int PSH_UP = (POS_FRAC_BITS >= 16) ? POS_FRAC_BITS - 16 : 0;
  localparam int PSH_DN = (POS_FRAC_BITS < 16) ? 16 - POS_FRAC_BITS : 0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CUTOFF = 3'd0,
    REG_BOX    = 3'd1,
    REG_STEP   = 3'd2,
    REG_SIGMA  = 3'd3,
    REG_EPS    = 3'd4,
    REG_FLOOR  = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic                  acc;
    logic signed [D_W-1:0] dx;
    logic signed [D_W-1:0] dy;
    logic signed [D_W-1:0] dz;
    logic [RT_W-1:0]       rr;
    logic [WORD_W-1:0]     w;
    logic [WORD_W-1:0]     u;
    logic [KICK_W-1:0]     fmag;
    logic                  fneg;
    logic                  clamped;
  } pair_t;

  function automatic logic signed [D_W-1:0] min_image(
    input logic [POS_W-1:0] a,
    input logic [POS_W-1:0] b,
    input logic [POS_W-1:0] len
  );
    logic signed [D_W-1:0] c;
    logic signed [D_W-1:0] l;
    logic signed [D_W-1:0] d;
    logic signed [D_W-1:0] res;
    c = $signed({{(D_W-POS_W){1'b0}}, b}) - $signed({{(D_W-POS_W){1'b0}}, a});
    l = $signed({{(D_W-POS_W){1'b0}}, len});
    if (c > 0) begin
      d   = c - l;
      res = (c < -d) ? c : d;
    end else begin
      d   = c + l;
      res = (-c < d) ? c : d;
    end
    return res;
  endfunction

  function automatic logic [MAG_W-1:0] mag_d(input logic signed [D_W-1:0] d);
    logic [D_W-1:0] m;
    m = d[D_W-1] ? D_W'(-d) : D_W'(d);
    return m[MAG_W-1:0];
  endfunction

  function automatic logic [WORD_W-1:0] sat_shr32(input logic [PROD_W-1:0] p);
    return (|p[PROD_W-1:96]) ? '1 : p[95:32];
  endfunction

  function automatic logic [WORD_W-1:0] sat_shr16(input logic [PROD_W-1:0] p);
    return (|p[PROD_W-1:80]) ? '1 : p[79:16];
  endfunction

  // rescale force numerator for the position fraction width
  function automatic logic [WORD_W-1:0] frac_adj(input logic [WORD_W-1:0] n);
    logic [WORD_W-1:0] up;
    up = (n > ({WORD_W{1'b1}} >> PSH_UP)) ? '1 : (n << PSH_UP);
    return up >> PSH_DN;
  endfunction

  function automatic logic [KICK_W-1:0] kick_fn(
    input logic [KICK_W+STEP_W-1:0] kp,
    input logic                     neg,
    input logic                     acc
  );
    logic [KICK_W-1:0] k;
    logic [KICK_W-1:0] res;
    k = kp[KICK_W+STEP_W-1:STEP_W];
    if (!acc || k == '0) begin
      res = '0;
    end else if (neg) begin
      res = (k > 32'h8000_0000) ? 32'h8000_0000 : (32'd0 - k);
    end else begin
      res = (k > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : k;
    end
    return res;
  endfunction

endpackage

### src/ljpk_sqrt.sv
// ----------------------------------------------------------------------------
// ljpk_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module ljpk_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_vld,
  input  logic [ljpk_pkg::R2_W-1:0]  in_val,
  input  ljpk_pkg::pair_t            in_side,
  output logic                       out_vld,
  output ljpk_pkg::pair_t            out_side
);
  import ljpk_pkg::*;

  localparam int REM_W = RT_W + 1;

  logic              vld_r  [SQRT_STAGES];
  logic [R2_W-1:0]   v_r    [SQRT_STAGES];
  logic [REM_W-1:0]  rem_r  [SQRT_STAGES];
  logic [RT_W-1:0]   root_r [SQRT_STAGES];
  pair_t             side_r [SQRT_STAGES];

  for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_stage
    logic              vld_src;
    logic [R2_W-1:0]   v_src;
    logic [REM_W-1:0]  rem_src;
    logic [RT_W-1:0]   root_src;
    pair_t             side_src;
    logic [REM_W+1:0]  rem_sh;
    logic [REM_W+1:0]  trial;
    logic [REM_W+1:0]  diff;
    logic              ge;

    if (i == 0) begin : g_first
      assign vld_src  = in_vld;
      assign v_src    = in_val;
      assign rem_src  = '0;
      assign root_src = '0;
      assign side_src = in_side;
    end else begin : g_next
      assign vld_src  = vld_r[i-1];
      assign v_src    = v_r[i-1];
      assign rem_src  = rem_r[i-1];
      assign root_src = root_r[i-1];
      assign side_src = side_r[i-1];
    end

    assign rem_sh = {rem_src, v_src[R2_W-1 -: 2]};
    assign trial  = {1'b0, root_src, 2'b01};
    assign ge     = rem_sh >= trial;
    assign diff   = ge ? rem_sh - trial : rem_sh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= vld_src;
      end
    end

    always_ff @(posedge clk) begin
      v_r[i]    <= v_src << 2;
      rem_r[i]  <= diff[REM_W-1:0];
      root_r[i] <= {root_src[RT_W-2:0], ge};
      side_r[i] <= side_src;
    end
  end

  always_comb begin
    out_side    = side_r[SQRT_STAGES-1];
    out_side.rr = root_r[SQRT_STAGES-1];
  end
  assign out_vld = vld_r[SQRT_STAGES-1];

endmodule

### src/ljpk_div.sv
// ----------------------------------------------------------------------------
// ljpk_div
// Pipelined restoring divider, 64-bit dividend by the pair distance.
// ----------------------------------------------------------------------------
module ljpk_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_vld,
  input  logic [ljpk_pkg::WORD_W-1:0]  in_num,
  input  ljpk_pkg::pair_t              in_side,
  output logic                         out_vld,
  output logic [ljpk_pkg::WORD_W-1:0]  out_quo,
  output ljpk_pkg::pair_t              out_side
);
  import ljpk_pkg::*;

  logic              vld_r  [DIV_STAGES];
  logic [WORD_W-1:0] nq_r   [DIV_STAGES];   // dividend bits out, quotient bits in
  logic [RT_W-1:0]   rem_r  [DIV_STAGES];
  pair_t             side_r [DIV_STAGES];

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
    logic              vld_src;
    logic [WORD_W-1:0] nq_src;
    logic [RT_W-1:0]   rem_src;
    pair_t             side_src;
    logic [RT_W:0]     rem_sh;
    logic [RT_W:0]     diff;
    logic              ge;

    if (i == 0) begin : g_first
      assign vld_src  = in_vld;
      assign nq_src   = in_num;
      assign rem_src  = '0;
      assign side_src = in_side;
    end else begin : g_next
      assign vld_src  = vld_r[i-1];
      assign nq_src   = nq_r[i-1];
      assign rem_src  = rem_r[i-1];
      assign side_src = side_r[i-1];
    end

    assign rem_sh = {rem_src, nq_src[WORD_W-1]};
    assign ge     = rem_sh >= {1'b0, side_src.rr};
    assign diff   = ge ? rem_sh - {1'b0, side_src.rr} : rem_sh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= vld_src;
      end
    end

    always_ff @(posedge clk) begin
      nq_r[i]   <= {nq_src[WORD_W-2:0], ge};
      rem_r[i]  <= diff[RT_W-1:0];
      side_r[i] <= side_src;
    end
  end

  assign out_vld  = vld_r[DIV_STAGES-1];
  assign out_quo  = nq_r[DIV_STAGES-1];
  assign out_side = side_r[DIV_STAGES-1];

endmodule

### src/ljpk_mul.sv
// ----------------------------------------------------------------------------
// ljpk_mul
// Two-stage 64x64 multiplier built from four 32x32 partial products.
// ----------------------------------------------------------------------------
module ljpk_mul (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_vld,
  input  logic [ljpk_pkg::WORD_W-1:0]  in_a,
  input  logic [ljpk_pkg::WORD_W-1:0]  in_b,
  input  ljpk_pkg::pair_t              in_side,
  output logic                         out_vld,
  output logic [ljpk_pkg::PROD_W-1:0]  out_prod,
  output ljpk_pkg::pair_t              out_side
);
  import ljpk_pkg::*;

  localparam int HW = WORD_W / 2;

  logic              vld1_r, vld2_r;
  logic [WORD_W-1:0] p00_r, p01_r, p10_r, p11_r;
  logic [PROD_W-1:0] prod_r;
  pair_t             side1_r, side2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    p00_r   <= in_a[HW-1:0] * in_b[HW-1:0];
    p01_r   <= in_a[HW-1:0] * in_b[WORD_W-1:HW];
    p10_r   <= in_a[WORD_W-1:HW] * in_b[HW-1:0];
    p11_r   <= in_a[WORD_W-1:HW] * in_b[WORD_W-1:HW];
    side1_r <= in_side;
    prod_r  <= {{WORD_W{1'b0}}, p00_r}
             + {{HW{1'b0}}, p01_r, {HW{1'b0}}}
             + {{HW{1'b0}}, p10_r, {HW{1'b0}}}
             + {p11_r, {WORD_W{1'b0}}};
    side2_r <= side1_r;
  end

  assign out_vld  = vld2_r;
  assign out_prod = prod_r;
  assign out_side = side2_r;

endmodule

### src/lennard_jones_pair_kick.sv
// ----------------------------------------------------------------------------
// lennard_jones_pair_kick
// Fixed-point Lennard-Jones pair kernel: minimum image, cutoff, force, kick.
// ----------------------------------------------------------------------------
// One pair is taken every cycle; busy is never raised. Each item's result
// appears on the out_ ports, marked by out_valid for one cycle, in order.
// Most of the pipeline depth lies in the 27-step square root and the three
// 64-step divider pipelines (sigma/r, force over r, kick over r). Results
// cannot be held off and nothing stalls.
// Configuration registers must be written only while no item is in flight.
module lennard_jones_pair_kick (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [ljpk_pkg::POS_W-1:0]          in_ref_x,
  input  logic [ljpk_pkg::POS_W-1:0]          in_ref_y,
  input  logic [ljpk_pkg::POS_W-1:0]          in_ref_z,
  input  logic [ljpk_pkg::POS_W-1:0]          in_nbr_x,
  input  logic [ljpk_pkg::POS_W-1:0]          in_nbr_y,
  input  logic [ljpk_pkg::POS_W-1:0]          in_nbr_z,
  input  logic                                cfg_we,
  input  logic [ljpk_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ljpk_pkg::CFG_W-1:0]          cfg_wdata,
  output logic                                out_valid,
  output logic signed [ljpk_pkg::KICK_W-1:0]  out_kick_x,
  output logic signed [ljpk_pkg::KICK_W-1:0]  out_kick_y,
  output logic signed [ljpk_pkg::KICK_W-1:0]  out_kick_z,
  output logic [ljpk_pkg::POS_W-1:0]          out_distance,
  output logic                                out_accepted,
  output logic                                out_clamped
);
  import ljpk_pkg::*;

  localparam logic [WORD_W-1:0] ONE_Q32 = 64'h1_0000_0000;

  // configuration
  logic [POS_W-1:0]   cutoff_r, box_r, sigma_r, eps_r;
  logic [STEP_W-1:0]  step_r;
  logic [CFG_W-1:0]   floor_r;
  logic [2*POS_W-1:0] cut2_r;
  logic [EPS24_W-1:0] eps24_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r <= 24'd163840;
      box_r    <= 24'd491520;
      step_r   <= 16'd6554;
      sigma_r  <= 24'd65536;
      eps_r    <= 24'd65536;
      floor_r  <= 32'hFFF6_68F6;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CUTOFF: cutoff_r <= cfg_wdata[POS_W-1:0];
        REG_BOX:    box_r    <= cfg_wdata[POS_W-1:0];
        REG_STEP:   step_r   <= cfg_wdata[STEP_W-1:0];
        REG_SIGMA:  sigma_r  <= cfg_wdata[POS_W-1:0];
        REG_EPS:    eps_r    <= cfg_wdata[POS_W-1:0];
        REG_FLOOR:  floor_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    cut2_r  <= cutoff_r * cutoff_r;
    eps24_r <= {1'b0, eps_r, 4'b0} + {2'b0, eps_r, 3'b0};
  end

  assign busy = 1'b0;

  // stage 1: minimum image
  logic  s1_vld_r;
  pair_t s1_r, s1_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else        s1_vld_r <= start && !busy;
  end

  always_comb begin
    s1_nxt    = '0;
    s1_nxt.dx = min_image(in_ref_x, in_nbr_x, box_r);
    s1_nxt.dy = min_image(in_ref_y, in_nbr_y, box_r);
    s1_nxt.dz = min_image(in_ref_z, in_nbr_z, box_r);
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
  end

  // stage 2: squares
  logic            s2_vld_r;
  pair_t           s2_r;
  logic [SQ_W-1:0] sqx_r, sqy_r, sqz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s2_vld_r <= 1'b0;
    else        s2_vld_r <= s1_vld_r;
  end

  always_ff @(posedge clk) begin
    s2_r  <= s1_r;
    sqx_r <= mag_d(s1_r.dx) * mag_d(s1_r.dx);
    sqy_r <= mag_d(s1_r.dy) * mag_d(s1_r.dy);
    sqz_r <= mag_d(s1_r.dz) * mag_d(s1_r.dz);
  end

  // stage 3: r^2 and acceptance
  logic            s3_vld_r;
  pair_t           s3_r, s3_nxt;
  logic [R2_W-1:0] r2_r;
  logic [R2_W-1:0] r2_sum;

  assign r2_sum = {2'b0, sqx_r} + {2'b0, sqy_r} + {2'b0, sqz_r};

  always_ff @(posedge clk) begin
    if (!rst_n) s3_vld_r <= 1'b0;
    else        s3_vld_r <= s2_vld_r;
  end

  always_comb begin
    s3_nxt     = s2_r;
    s3_nxt.acc = !s2_r.dx[D_W-1] && (r2_sum != '0)
                 && (r2_sum <= {{(R2_W-2*POS_W){1'b0}}, cut2_r});
  end

  always_ff @(posedge clk) begin
    s3_r <= s3_nxt;
    r2_r <= r2_sum;
  end

  // distance
  logic  sq_vld;
  pair_t sq_side;

  ljpk_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n),
    .in_vld(s3_vld_r), .in_val(r2_r), .in_side(s3_r),
    .out_vld(sq_vld), .out_side(sq_side)
  );

  // w = sigma / r in Q32
  logic              d1_vld;
  logic [WORD_W-1:0] d1_q;
  pair_t             d1_side, m1_in_side;

  ljpk_div u_div_w (
    .clk(clk), .rst_n(rst_n),
    .in_vld(sq_vld), .in_num({8'b0, sigma_r, 32'b0}), .in_side(sq_side),
    .out_vld(d1_vld), .out_quo(d1_q), .out_side(d1_side)
  );

  always_comb begin
    m1_in_side   = d1_side;
    m1_in_side.w = d1_q;
  end

  // w^2
  logic              m1_vld, w2_vld_r;
  logic [PROD_W-1:0] m1_prod;
  pair_t             m1_side, w2_side_r;
  logic [WORD_W-1:0] w2_r;

  ljpk_mul u_mul_w2 (
    .clk(clk), .rst_n(rst_n),
    .in_vld(d1_vld), .in_a(d1_q), .in_b(d1_q), .in_side(m1_in_side),
    .out_vld(m1_vld), .out_prod(m1_prod), .out_side(m1_side)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) w2_vld_r <= 1'b0;
    else        w2_vld_r <= m1_vld;
  end

  always_ff @(posedge clk) begin
    w2_r      <= sat_shr32(m1_prod);
    w2_side_r <= m1_side;
  end

  // w^3
  logic              m2_vld, w3_vld_r;
  logic [PROD_W-1:0] m2_prod;
  pair_t             m2_side, w3_side_r;
  logic [WORD_W-1:0] w3_r;

  ljpk_mul u_mul_w3 (
    .clk(clk), .rst_n(rst_n),
    .in_vld(w2_vld_r), .in_a(w2_r), .in_b(w2_side_r.w), .in_side(w2_side_r),
    .out_vld(m2_vld), .out_prod(m2_prod), .out_side(m2_side)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) w3_vld_r <= 1'b0;
    else        w3_vld_r <= m2_vld;
  end

  always_ff @(posedge clk) begin
    w3_r      <= sat_shr32(m2_prod);
    w3_side_r <= m2_side;
  end

  // u = w^6
  logic              m3_vld, u_vld_r;
  logic [PROD_W-1:0] m3_prod;
  pair_t             m3_side, u_side_r;
  logic [WORD_W-1:0] u_r;

  ljpk_mul u_mul_u (
    .clk(clk), .rst_n(rst_n),
    .in_vld(w3_vld_r), .in_a(w3_r), .in_b(w3_r), .in_side(w3_side_r),
    .out_vld(m3_vld), .out_prod(m3_prod), .out_side(m3_side)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) u_vld_r <= 1'b0;
    else        u_vld_r <= m3_vld;
  end

  always_ff @(posedge clk) begin
    u_r      <= sat_shr32(m3_prod);
    u_side_r <= m3_side;
  end

  // |1 - 2u| and force sign
  logic              tu_vld_r;
  pair_t             tu_side_r, tu_side_nxt;
  logic [WORD_W-1:0] dm_r;
  logic [WORD_W-1:0] two_u;
  logic              u_neg;

  assign two_u = u_r[WORD_W-1] ? '1 : {u_r[WORD_W-2:0], 1'b0};
  assign u_neg = two_u > ONE_Q32;

  always_ff @(posedge clk) begin
    if (!rst_n) tu_vld_r <= 1'b0;
    else        tu_vld_r <= u_vld_r;
  end

  always_comb begin
    tu_side_nxt      = u_side_r;
    tu_side_nxt.u    = u_r;
    tu_side_nxt.fneg = u_neg;
  end

  always_ff @(posedge clk) begin
    tu_side_r <= tu_side_nxt;
    dm_r      <= u_neg ? two_u - ONE_Q32 : ONE_Q32 - two_u;
  end

  // m = u * |1 - 2u|
  logic              m4_vld, mm_vld_r;
  logic [PROD_W-1:0] m4_prod;
  pair_t             m4_side, mm_side_r;
  logic [WORD_W-1:0] mm_r;

  ljpk_mul u_mul_m (
    .clk(clk), .rst_n(rst_n),
    .in_vld(tu_vld_r), .in_a(tu_side_r.u), .in_b(dm_r), .in_side(tu_side_r),
    .out_vld(m4_vld), .out_prod(m4_prod), .out_side(m4_side)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) mm_vld_r <= 1'b0;
    else        mm_vld_r <= m4_vld;
  end

  always_ff @(posedge clk) begin
    mm_r      <= sat_shr32(m4_prod);
    mm_side_r <= m4_side;
  end

  // n = m * 24e
  logic              m5_vld, n_vld_r;
  logic [PROD_W-1:0] m5_prod;
  pair_t             m5_side, n_side_r;
  logic [WORD_W-1:0] n_r;

  ljpk_mul u_mul_n (
    .clk(clk), .rst_n(rst_n),
    .in_vld(mm_vld_r), .in_a(mm_r), .in_b({{(WORD_W-EPS24_W){1'b0}}, eps24_r}),
    .in_side(mm_side_r),
    .out_vld(m5_vld), .out_prod(m5_prod), .out_side(m5_side)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) n_vld_r <= 1'b0;
    else        n_vld_r <= m5_vld;
  end

  always_ff @(posedge clk) begin
    n_r      <= frac_adj(sat_shr16(m5_prod));
    n_side_r <= m5_side;
  end

  // |f| = n / r
  logic              d2_vld;
  logic [WORD_W-1:0] d2_q;
  pair_t             d2_side;

  ljpk_div u_div_f (
    .clk(clk), .rst_n(rst_n),
    .in_vld(n_vld_r), .in_num(n_r), .in_side(n_side_r),
    .out_vld(d2_vld), .out_quo(d2_q), .out_side(d2_side)
  );

  // saturate, sign and floor
  logic                f_vld_r;
  pair_t               f_side_r, f_side_nxt;
  logic [KICK_W-1:0]   fm_sat;
  logic signed [KICK_W:0] f_raw, f_min, f_sel;
  logic [KICK_W:0]     f_abs;
  logic                f_clmp;

  always_comb begin
    if (d2_side.fneg) begin
      fm_sat = (d2_q > 64'h8000_0000) ? 32'h8000_0000 : d2_q[KICK_W-1:0];
      f_raw  = -$signed({1'b0, fm_sat});
    end else begin
      fm_sat = (d2_q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : d2_q[KICK_W-1:0];
      f_raw  = $signed({1'b0, fm_sat});
    end
    f_min  = $signed({floor_r[CFG_W-1], floor_r});
    f_clmp = d2_side.acc && (f_raw < f_min);
    f_sel  = f_clmp ? f_min : f_raw;
    f_abs  = f_sel[KICK_W] ? (KICK_W+1)'(-f_sel) : f_sel;
  end

  always_comb begin
    f_side_nxt         = d2_side;
    f_side_nxt.fmag    = f_abs[KICK_W-1:0];
    f_side_nxt.fneg    = f_sel[KICK_W];
    f_side_nxt.clamped = f_clmp;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) f_vld_r <= 1'b0;
    else        f_vld_r <= d2_vld;
  end

  always_ff @(posedge clk) begin
    f_side_r <= f_side_nxt;
  end

  // |f| * |d| per axis
  localparam int FD_W = KICK_W + MAG_W;

  logic            p_vld_r;
  pair_t           p_side_r;
  logic [FD_W-1:0] px_r, py_r, pz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) p_vld_r <= 1'b0;
    else        p_vld_r <= f_vld_r;
  end

  always_ff @(posedge clk) begin
    p_side_r <= f_side_r;
    px_r     <= f_side_r.fmag * mag_d(f_side_r.dx);
    py_r     <= f_side_r.fmag * mag_d(f_side_r.dy);
    pz_r     <= f_side_r.fmag * mag_d(f_side_r.dz);
  end

  // q = |f| * |d| / r; x lane carries the item's side data
  logic              d3_vld;
  logic [WORD_W-1:0] qx, qy, qz;
  pair_t             d3_side;

  ljpk_div u_div_kx (
    .clk(clk), .rst_n(rst_n),
    .in_vld(p_vld_r), .in_num({{(WORD_W-FD_W){1'b0}}, px_r}), .in_side(p_side_r),
    .out_vld(d3_vld), .out_quo(qx), .out_side(d3_side)
  );

  ljpk_div u_div_ky (
    .clk(clk), .rst_n(rst_n),
    .in_vld(p_vld_r), .in_num({{(WORD_W-FD_W){1'b0}}, py_r}), .in_side(p_side_r),
    .out_vld(), .out_quo(qy), .out_side()
  );

  ljpk_div u_div_kz (
    .clk(clk), .rst_n(rst_n),
    .in_vld(p_vld_r), .in_num({{(WORD_W-FD_W){1'b0}}, pz_r}), .in_side(p_side_r),
    .out_vld(), .out_quo(qz), .out_side()
  );

  // scale by time step; q never exceeds |f| so 32 bits hold it
  logic                     k_vld_r;
  pair_t                    k_side_r;
  logic [KICK_W+STEP_W-1:0] kx_r, ky_r, kz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) k_vld_r <= 1'b0;
    else        k_vld_r <= d3_vld;
  end

  always_ff @(posedge clk) begin
    k_side_r <= d3_side;
    kx_r     <= qx[KICK_W-1:0] * step_r;
    ky_r     <= qy[KICK_W-1:0] * step_r;
    kz_r     <= qz[KICK_W-1:0] * step_r;
  end

  // output registers
  logic              out_valid_r, out_acc_r, out_clmp_r;
  logic [KICK_W-1:0] out_kx_r, out_ky_r, out_kz_r;
  logic [POS_W-1:0]  out_dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= k_vld_r;
  end

  always_ff @(posedge clk) begin
    out_kx_r   <= kick_fn(kx_r, k_side_r.fneg ^ k_side_r.dx[D_W-1], k_side_r.acc);
    out_ky_r   <= kick_fn(ky_r, k_side_r.fneg ^ k_side_r.dy[D_W-1], k_side_r.acc);
    out_kz_r   <= kick_fn(kz_r, k_side_r.fneg ^ k_side_r.dz[D_W-1], k_side_r.acc);
    out_dist_r <= (k_side_r.rr > {{(RT_W-POS_W){1'b0}}, {POS_W{1'b1}}})
                  ? {POS_W{1'b1}} : k_side_r.rr[POS_W-1:0];
    out_acc_r  <= k_side_r.acc;
    out_clmp_r <= k_side_r.acc && k_side_r.clamped;
  end

  assign out_valid    = out_valid_r;
  assign out_kick_x   = $signed(out_kx_r);
  assign out_kick_y   = $signed(out_ky_r);
  assign out_kick_z   = $signed(out_kz_r);
  assign out_distance = out_dist_r;
  assign out_accepted = out_acc_r;
  assign out_clamped  = out_clmp_r;

  a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##PIPE_LAT out_valid)
    else $error("item result missing at fixed latency");

  a_reject_no_kick: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_accepted) |->
      (out_kick_x == '0 && out_kick_y == '0 && out_kick_z == '0 && !out_clamped))
    else $error("rejected pair carries a kick");

  a_clamp_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_clamped) |-> out_accepted)
    else $error("clamp flagged on rejected pair");

  a_accept_nonzero_dist: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_accepted) |-> (out_distance != '0))
    else $error("accepted pair with zero distance");

endmodule
